### sv/free_list_heap_allocator_core_defines.svh
// Assertion macros shared by the allocator core.
`ifndef FREE_LIST_HEAP_ALLOCATOR_CORE_DEFINES_SVH
`define FREE_LIST_HEAP_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define FLHA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define FLHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/flha_pkg.sv
// Shared types, constants and controller/datapath interface of the allocator.
package flha_pkg;

  localparam int ARENA_UNITS = 16384;
  localparam int UNIT_SHIFT  = 4;
  localparam int ADDR_W      = $clog2(ARENA_UNITS);
  localparam int SIZE_W      = ADDR_W + 1;
  localparam int NEED_W      = 33 - UNIT_SHIFT;
  localparam int WALK_LIMIT  = 3 * ARENA_UNITS + 8;
  localparam int STEP_W      = $clog2(WALK_LIMIT + 1);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int GROW_RESET  = 1024;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [ADDR_W+1:0] wide_t;
  typedef logic [NEED_W-1:0] need_t;
  typedef logic [NEED_W:0]   sum_t;
  typedef logic [STEP_W-1:0] step_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [1:0] {
    FUNC_ALLOC  = 2'd0,
    FUNC_CALLOC = 2'd1,
    FUNC_FREE   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef struct packed {
    addr_t next;
    size_t size;
  } hdr_t;

  localparam int HDR_W = $bits(hdr_t);

  typedef enum logic [4:0] {
    S_IDLE, S_MUL, S_SETUP,
    S_R_START, S_R_WALK, S_R_B, S_R_Q, S_R_WB, S_R_RDP, S_R_P,
    S_A_RDR, S_A_R, S_A_CHK, S_A_RDN, S_A_N,
    S_G, S_G_W, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_MUL, OP_SETUP,
    OP_REL_START, OP_REL_STEP, OP_REL_FOUND, OP_REL_NOMERGE, OP_REL_MERGE_RD,
    OP_REL_MERGE, OP_REL_WB, OP_REL_RDP, OP_REL_JOIN_P, OP_REL_LINK_P,
    OP_ALLOC_START, OP_ALLOC_FIRST, OP_ALLOC_STEP, OP_ALLOC_EXACT, OP_ALLOC_CARVE,
    OP_ALLOC_RDNEW, OP_ALLOC_TAIL, OP_GROW, OP_GROW_WR, OP_RES_FAIL, OP_PUSH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   count;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  free_ok;
    logic  found;
    logic  n_limit;
    logic  merge_next;
    logic  merge_prev;
    logic  fit;
    logic  exact;
    logic  at_rover;
    logic  steps_limit;
    logic  tail_in;
    logic  grow_ok;
    logic  out_busy;
  } stat_t;

endpackage

### sv/flha_ram.sv
// Generic single-write, single-read RAM with registered read data.
module flha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/flha_dp.sv
// Datapath of the allocator: header memory, list pointers, arithmetic and result word.
module flha_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [1:0]             in_func,
  input  logic [31:0]            in_byte_count,
  input  logic [15:0]            in_elem_count,
  input  logic [15:0]            in_elem_size,
  input  logic [13:0]            in_free_address,
  input  logic                   cfg_valid,
  input  logic [14:0]            cfg_grow_units,
  input  flha_pkg::cmd_t         cmd,
  output flha_pkg::stat_t        stat,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [13:0]            out_block_address,
  output logic                   out_status
);

  flha_pkg::func_t   func_r;
  logic [31:0]       byte_r;
  logic [15:0]       ecnt_r;
  logic [15:0]       esize_r;
  flha_pkg::addr_t   faddr_r;
  logic [31:0]       prod_r;
  flha_pkg::need_t   need_r;
  flha_pkg::addr_t   p_r;
  flha_pkg::addr_t   prev_r;
  flha_pkg::size_t   prev_size_r;
  flha_pkg::addr_t   q_r;
  flha_pkg::addr_t   bp_r;
  flha_pkg::addr_t   bnext_r;
  flha_pkg::size_t   bsize_r;
  flha_pkg::wide_t   pnew_r;
  flha_pkg::size_t   nu_r;
  flha_pkg::cnt_t    n_r;
  flha_pkg::step_t   steps_r;
  flha_pkg::addr_t   rover_r;
  logic              list_ready_r;
  flha_pkg::size_t   break_r;
  flha_pkg::size_t   grow_r;
  flha_pkg::addr_t   res_addr_r;
  logic              res_status_r;
  logic              out_valid_r;
  flha_pkg::addr_t   out_addr_r;
  logic              out_status_r;

  logic              ram_we;
  flha_pkg::addr_t   ram_waddr;
  flha_pkg::hdr_t    ram_wdata;
  flha_pkg::addr_t   ram_raddr;
  logic [flha_pkg::HDR_W-1:0] ram_rdata;
  flha_pkg::hdr_t    rd;

  logic [32:0]       bytes_c;
  flha_pkg::need_t   need_c;
  flha_pkg::addr_t   fa_m1;
  flha_pkg::size_t   diff_c;
  flha_pkg::wide_t   pnew_c;
  flha_pkg::need_t   nu_c;
  logic              ensure_c;

  flha_ram #(
    .WIDTH (flha_pkg::HDR_W),
    .DEPTH (flha_pkg::ARENA_UNITS)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd = flha_pkg::hdr_t'(ram_rdata);

  // Round the byte count up to whole units and add the header unit.
  assign bytes_c = ((func_r == flha_pkg::FUNC_ALLOC) ? {1'b0, byte_r} : {1'b0, prod_r})
                   + 33'((1 << flha_pkg::UNIT_SHIFT) - 1);
  assign need_c  = bytes_c[32:flha_pkg::UNIT_SHIFT] + flha_pkg::need_t'(1);
  assign fa_m1   = faddr_r - flha_pkg::addr_t'(1);
  assign diff_c  = rd.size - need_r[flha_pkg::SIZE_W-1:0];
  assign pnew_c  = flha_pkg::wide_t'(p_r) + flha_pkg::wide_t'(diff_c);
  assign nu_c    = (need_r < flha_pkg::need_t'(grow_r)) ? flha_pkg::need_t'(grow_r) : need_r;
  assign ensure_c = (func_r != flha_pkg::FUNC_NONE) && !list_ready_r;

  always_comb begin
    stat.func        = func_r;
    stat.free_ok     = (faddr_r >= flha_pkg::addr_t'(2)) &&
                       (flha_pkg::size_t'(fa_m1) < break_r);
    stat.found       = ((bp_r > p_r) && (bp_r < rd.next)) ||
                       ((p_r >= rd.next) && ((bp_r > p_r) || (bp_r < rd.next)));
    stat.n_limit     = n_r >= flha_pkg::cnt_t'(flha_pkg::ARENA_UNITS);
    stat.merge_next  = (flha_pkg::wide_t'(bp_r) + flha_pkg::wide_t'(rd.size))
                       == flha_pkg::wide_t'(q_r);
    stat.merge_prev  = (flha_pkg::wide_t'(p_r) + flha_pkg::wide_t'(rd.size))
                       == flha_pkg::wide_t'(bp_r);
    stat.fit         = flha_pkg::need_t'(rd.size) >= need_r;
    stat.exact       = flha_pkg::need_t'(rd.size) == need_r;
    stat.at_rover    = p_r == rover_r;
    stat.steps_limit = steps_r >= flha_pkg::step_t'(flha_pkg::WALK_LIMIT);
    stat.tail_in     = pnew_c < flha_pkg::wide_t'(flha_pkg::ARENA_UNITS);
    stat.grow_ok     = (flha_pkg::sum_t'(break_r) + flha_pkg::sum_t'(nu_c))
                       <= flha_pkg::sum_t'(flha_pkg::ARENA_UNITS);
    stat.out_busy    = out_valid_r && !out_ready;
  end

  // Header memory addressing for each datapath operation.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    unique case (cmd.op)
      flha_pkg::OP_SETUP: begin
        ram_we = ensure_c;
      end
      flha_pkg::OP_REL_START:    ram_raddr = rover_r;
      flha_pkg::OP_REL_STEP:     ram_raddr = rd.next;
      flha_pkg::OP_REL_FOUND:    ram_raddr = bp_r;
      flha_pkg::OP_REL_MERGE_RD: ram_raddr = q_r;
      flha_pkg::OP_REL_WB: begin
        ram_we    = 1'b1;
        ram_waddr = bp_r;
        ram_wdata = '{next: bnext_r, size: bsize_r};
      end
      flha_pkg::OP_REL_RDP:      ram_raddr = p_r;
      flha_pkg::OP_REL_JOIN_P: begin
        ram_we    = 1'b1;
        ram_waddr = p_r;
        ram_wdata = '{next: bnext_r, size: rd.size + bsize_r};
      end
      flha_pkg::OP_REL_LINK_P: begin
        ram_we    = 1'b1;
        ram_waddr = p_r;
        ram_wdata = '{next: bp_r, size: rd.size};
      end
      flha_pkg::OP_ALLOC_START:  ram_raddr = rover_r;
      flha_pkg::OP_ALLOC_FIRST:  ram_raddr = rd.next;
      flha_pkg::OP_ALLOC_STEP:   ram_raddr = rd.next;
      flha_pkg::OP_ALLOC_EXACT: begin
        ram_we    = 1'b1;
        ram_waddr = prev_r;
        ram_wdata = '{next: rd.next, size: prev_size_r};
      end
      flha_pkg::OP_ALLOC_CARVE: begin
        ram_we    = 1'b1;
        ram_waddr = p_r;
        ram_wdata = '{next: rd.next, size: diff_c};
      end
      flha_pkg::OP_ALLOC_RDNEW:  ram_raddr = pnew_r[flha_pkg::ADDR_W-1:0];
      flha_pkg::OP_ALLOC_TAIL: begin
        ram_we    = 1'b1;
        ram_waddr = pnew_r[flha_pkg::ADDR_W-1:0];
        ram_wdata = '{next: rd.next, size: need_r[flha_pkg::SIZE_W-1:0]};
      end
      flha_pkg::OP_GROW:         ram_raddr = break_r[flha_pkg::ADDR_W-1:0];
      flha_pkg::OP_GROW_WR: begin
        ram_we    = 1'b1;
        ram_waddr = bp_r;
        ram_wdata = '{next: rd.next, size: nu_r};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rover_r      <= '0;
      list_ready_r <= 1'b0;
      break_r      <= flha_pkg::size_t'(1);
      grow_r       <= flha_pkg::size_t'(flha_pkg::GROW_RESET);
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        grow_r <= cfg_grow_units;
      end
      if (cmd.op == flha_pkg::OP_PUSH) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (cmd.op)
        flha_pkg::OP_SETUP: begin
          if (ensure_c) begin
            rover_r      <= '0;
            list_ready_r <= 1'b1;
          end
        end
        flha_pkg::OP_REL_JOIN_P,
        flha_pkg::OP_REL_LINK_P:  rover_r <= p_r;
        flha_pkg::OP_ALLOC_EXACT,
        flha_pkg::OP_ALLOC_CARVE: rover_r <= prev_r;
        flha_pkg::OP_GROW:        break_r <= break_r + nu_c[flha_pkg::SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      flha_pkg::OP_LOAD: begin
        func_r  <= flha_pkg::func_t'(in_func);
        byte_r  <= in_byte_count;
        ecnt_r  <= in_elem_count;
        esize_r <= in_elem_size;
        faddr_r <= in_free_address;
      end
      flha_pkg::OP_MUL: prod_r <= ecnt_r * esize_r;
      flha_pkg::OP_SETUP: begin
        need_r       <= need_c;
        bp_r         <= fa_m1;
        steps_r      <= '0;
        res_addr_r   <= '0;
        res_status_r <= 1'b0;
      end
      flha_pkg::OP_REL_START: begin
        p_r <= rover_r;
        n_r <= '0;
      end
      flha_pkg::OP_REL_STEP: begin
        p_r <= rd.next;
        n_r <= n_r + flha_pkg::cnt_t'(1);
      end
      flha_pkg::OP_REL_FOUND: q_r <= rd.next;
      flha_pkg::OP_REL_NOMERGE: begin
        bnext_r <= q_r;
        bsize_r <= rd.size;
      end
      flha_pkg::OP_REL_MERGE_RD: bsize_r <= rd.size;
      flha_pkg::OP_REL_MERGE: begin
        bnext_r <= rd.next;
        bsize_r <= bsize_r + rd.size;
      end
      flha_pkg::OP_ALLOC_START: prev_r <= rover_r;
      flha_pkg::OP_ALLOC_FIRST: begin
        prev_size_r <= rd.size;
        p_r         <= rd.next;
        if (cmd.count) begin
          steps_r <= steps_r + flha_pkg::step_t'(1);
        end
      end
      flha_pkg::OP_ALLOC_STEP: begin
        prev_r      <= p_r;
        prev_size_r <= rd.size;
        p_r         <= rd.next;
        steps_r     <= steps_r + flha_pkg::step_t'(1);
      end
      flha_pkg::OP_ALLOC_EXACT: begin
        res_addr_r   <= p_r + flha_pkg::addr_t'(1);
        res_status_r <= 1'b0;
      end
      flha_pkg::OP_ALLOC_CARVE: begin
        pnew_r       <= pnew_c;
        res_addr_r   <= pnew_c[flha_pkg::ADDR_W-1:0] + flha_pkg::addr_t'(1);
        res_status_r <= 1'b0;
      end
      flha_pkg::OP_GROW: begin
        bp_r <= break_r[flha_pkg::ADDR_W-1:0];
        nu_r <= nu_c[flha_pkg::SIZE_W-1:0];
      end
      flha_pkg::OP_RES_FAIL: begin
        res_addr_r   <= '0;
        res_status_r <= 1'b1;
      end
      flha_pkg::OP_PUSH: begin
        out_addr_r   <= res_addr_r;
        out_status_r <= res_status_r;
      end
      default: begin
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_block_address = out_addr_r;
  assign out_status        = out_status_r;

endmodule

### sv/flha_ctrl.sv
// Controller of the allocator: sequences list walks, merges and growth.
module flha_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  flha_pkg::stat_t stat,
  output flha_pkg::cmd_t  cmd
);

  flha_pkg::state_t state_r, state_nxt;
  logic             from_grow_r, from_grow_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= flha_pkg::S_IDLE;
      from_grow_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      from_grow_r <= from_grow_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    from_grow_nxt = from_grow_r;
    unique case (state_r)
      flha_pkg::S_IDLE:  if (in_valid) state_nxt = flha_pkg::S_MUL;
      flha_pkg::S_MUL:   state_nxt = flha_pkg::S_SETUP;
      flha_pkg::S_SETUP: begin
        from_grow_nxt = 1'b0;
        priority if (stat.func == flha_pkg::FUNC_ALLOC || stat.func == flha_pkg::FUNC_CALLOC)
          state_nxt = flha_pkg::S_A_RDR;
        else if (stat.func == flha_pkg::FUNC_FREE && stat.free_ok)
          state_nxt = flha_pkg::S_R_START;
        else
          state_nxt = flha_pkg::S_DONE;
      end
      flha_pkg::S_R_START: state_nxt = flha_pkg::S_R_WALK;
      flha_pkg::S_R_WALK: begin
        priority if (stat.found) state_nxt = flha_pkg::S_R_B;
        else if (stat.n_limit)   state_nxt = flha_pkg::S_DONE;
        else                     state_nxt = flha_pkg::S_R_WALK;
      end
      flha_pkg::S_R_B:   state_nxt = stat.merge_next ? flha_pkg::S_R_Q : flha_pkg::S_R_WB;
      flha_pkg::S_R_Q:   state_nxt = flha_pkg::S_R_WB;
      flha_pkg::S_R_WB:  state_nxt = flha_pkg::S_R_RDP;
      flha_pkg::S_R_RDP: state_nxt = flha_pkg::S_R_P;
      flha_pkg::S_R_P:   state_nxt = from_grow_r ? flha_pkg::S_A_RDR : flha_pkg::S_DONE;
      flha_pkg::S_A_RDR: state_nxt = flha_pkg::S_A_R;
      flha_pkg::S_A_R: begin
        state_nxt = (from_grow_r && stat.steps_limit) ? flha_pkg::S_DONE : flha_pkg::S_A_CHK;
      end
      flha_pkg::S_A_CHK: begin
        priority if (stat.fit && (stat.exact || !stat.tail_in))
          state_nxt = flha_pkg::S_DONE;
        else if (stat.fit)         state_nxt = flha_pkg::S_A_RDN;
        else if (stat.at_rover)    state_nxt = flha_pkg::S_G;
        else if (stat.steps_limit) state_nxt = flha_pkg::S_DONE;
        else                       state_nxt = flha_pkg::S_A_CHK;
      end
      flha_pkg::S_A_RDN: state_nxt = flha_pkg::S_A_N;
      flha_pkg::S_A_N:   state_nxt = flha_pkg::S_DONE;
      flha_pkg::S_G:     state_nxt = stat.grow_ok ? flha_pkg::S_G_W : flha_pkg::S_DONE;
      flha_pkg::S_G_W: begin
        from_grow_nxt = 1'b1;
        state_nxt     = flha_pkg::S_R_START;
      end
      flha_pkg::S_DONE:  if (!stat.out_busy) state_nxt = flha_pkg::S_IDLE;
      default:           state_nxt = flha_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op    = flha_pkg::OP_NOP;
    cmd.count = from_grow_r;
    unique case (state_r)
      flha_pkg::S_IDLE:    if (in_valid) cmd.op = flha_pkg::OP_LOAD;
      flha_pkg::S_MUL:     cmd.op = flha_pkg::OP_MUL;
      flha_pkg::S_SETUP:   cmd.op = flha_pkg::OP_SETUP;
      flha_pkg::S_R_START: cmd.op = flha_pkg::OP_REL_START;
      flha_pkg::S_R_WALK: begin
        // A walk that runs too long fails the allocation that grew the arena.
        priority if (stat.found)             cmd.op = flha_pkg::OP_REL_FOUND;
        else if (stat.n_limit && from_grow_r) cmd.op = flha_pkg::OP_RES_FAIL;
        else if (stat.n_limit)                cmd.op = flha_pkg::OP_NOP;
        else                                  cmd.op = flha_pkg::OP_REL_STEP;
      end
      flha_pkg::S_R_B: begin
        cmd.op = stat.merge_next ? flha_pkg::OP_REL_MERGE_RD : flha_pkg::OP_REL_NOMERGE;
      end
      flha_pkg::S_R_Q:     cmd.op = flha_pkg::OP_REL_MERGE;
      flha_pkg::S_R_WB:    cmd.op = flha_pkg::OP_REL_WB;
      flha_pkg::S_R_RDP:   cmd.op = flha_pkg::OP_REL_RDP;
      flha_pkg::S_R_P: begin
        cmd.op = stat.merge_prev ? flha_pkg::OP_REL_JOIN_P : flha_pkg::OP_REL_LINK_P;
      end
      flha_pkg::S_A_RDR:   cmd.op = flha_pkg::OP_ALLOC_START;
      flha_pkg::S_A_R: begin
        cmd.op = (from_grow_r && stat.steps_limit) ? flha_pkg::OP_RES_FAIL
                                                   : flha_pkg::OP_ALLOC_FIRST;
      end
      flha_pkg::S_A_CHK: begin
        priority if (stat.fit && stat.exact) cmd.op = flha_pkg::OP_ALLOC_EXACT;
        else if (stat.fit)                   cmd.op = flha_pkg::OP_ALLOC_CARVE;
        else if (stat.at_rover)              cmd.op = flha_pkg::OP_NOP;
        else if (stat.steps_limit)           cmd.op = flha_pkg::OP_RES_FAIL;
        else                                 cmd.op = flha_pkg::OP_ALLOC_STEP;
      end
      flha_pkg::S_A_RDN:   cmd.op = flha_pkg::OP_ALLOC_RDNEW;
      flha_pkg::S_A_N:     cmd.op = flha_pkg::OP_ALLOC_TAIL;
      flha_pkg::S_G:       cmd.op = stat.grow_ok ? flha_pkg::OP_GROW : flha_pkg::OP_RES_FAIL;
      flha_pkg::S_G_W:     cmd.op = flha_pkg::OP_GROW_WR;
      flha_pkg::S_DONE:    if (!stat.out_busy) cmd.op = flha_pkg::OP_PUSH;
      default:             cmd.op = flha_pkg::OP_NOP;
    endcase
  end

  assign in_ready = state_r == flha_pkg::S_IDLE;

endmodule

### sv/free_list_heap_allocator_core.sv
// Top level of the first-fit circular free-list heap allocator.
// After the input word is taken, an allocation walks the free list from the rover until a
// block fits, and a carve then writes the tail header; a free walks the list to its place and
// may merge into the next block; a rejected free or an unused selector goes to the result.
// One word at a time: a new word is taken only after the result has been pushed.
// Reset (rst_n low at a clock edge) empties the list state and sets grow_units to 1024.
`include "free_list_heap_allocator_core_defines.svh"

module free_list_heap_allocator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_byte_count,
  input  logic [15:0] in_elem_count,
  input  logic [15:0] in_elem_size,
  input  logic [13:0] in_free_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [13:0] out_block_address,
  output logic        out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [14:0] cfg_grow_units
);

  flha_pkg::cmd_t  cmd;
  flha_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  flha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  flha_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_func           (in_func),
    .in_byte_count     (in_byte_count),
    .in_elem_count     (in_elem_count),
    .in_elem_size      (in_elem_size),
    .in_free_address   (in_free_address),
    .cfg_valid         (cfg_valid),
    .cfg_grow_units    (cfg_grow_units),
    .cmd               (cmd),
    .stat              (stat),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_block_address (out_block_address),
    .out_status        (out_status)
  );

  `FLHA_ASSERT_NEXT(a_one_word_in_flight, in_valid && in_ready, !in_ready, "second word accepted while busy")
  `FLHA_ASSERT_NOW(a_push_into_free_slot, cmd.op == flha_pkg::OP_PUSH, !stat.out_busy, "result pushed over a waiting word")
  `FLHA_ASSERT_NOW(a_fail_has_no_block, out_valid && out_status, out_block_address == 14'd0, "failed allocation returned a block")

endmodule

### tb/sv/free_list_heap_allocator_core_test.sv
// Self-checking testbench for the first-fit free-list heap allocator core.
`timescale 1ns / 100ps

module free_list_heap_allocator_core_test;
  import flha_pkg::*;

  typedef struct {
    logic [13:0] block_address;
    logic        status;
  } alloc_result_t;

  // Shadow allocator: mirrors the header store, rover, break and grow setting.
  class heap_scoreboard;
    int unsigned   hdr_next[ARENA_UNITS];
    int unsigned   hdr_size[ARENA_UNITS];
    int unsigned   rover;
    int unsigned   arena_break;
    int unsigned   grow_units;
    bit            list_ready;
    alloc_result_t pending[$];
    int unsigned   live_blocks[$];
    int            n_alloc_ok;
    int            n_alloc_fail;
    int            n_free;

    function new();
      rover = 0;
      arena_break = 1;
      grow_units = GROW_RESET;
      list_ready = 0;
    endfunction

    function int unsigned nx(int unsigned i);
      return (i < ARENA_UNITS) ? hdr_next[i] : 0;
    endfunction

    function int unsigned sz(int unsigned i);
      return (i < ARENA_UNITS) ? hdr_size[i] : 0;
    endfunction

    function void put_next(int unsigned i, int unsigned v);
      if (i < ARENA_UNITS) hdr_next[i] = v;
    endfunction

    function void put_size(int unsigned i, int unsigned v);
      if (i < ARENA_UNITS) hdr_size[i] = v;
    endfunction

    function void setup_list();
      if (!list_ready) begin
        hdr_next[0] = 0;
        hdr_size[0] = 0;
        rover = 0;
        list_ready = 1;
      end
    endfunction

    // Address-ordered insertion with merging on both sides.
    function bit insert_block(int unsigned bp);
      int unsigned p;
      int unsigned q;
      int unsigned n;
      p = rover;
      n = 0;
      while (!(bp > p && bp < nx(p))) begin
        if (p >= nx(p) && (bp > p || bp < nx(p))) break;
        p = nx(p);
        n++;
        if (n > ARENA_UNITS) return 0;
      end
      q = nx(p);
      if (longint'(bp) + sz(bp) == q) begin
        put_size(bp, sz(bp) + sz(q));
        put_next(bp, nx(q));
      end else begin
        put_next(bp, q);
      end
      if (longint'(p) + sz(p) == bp) begin
        put_size(p, sz(p) + sz(bp));
        put_next(p, nx(bp));
      end else begin
        put_next(p, bp);
      end
      rover = p;
      return 1;
    endfunction

    function bit grow_arena(longint unsigned need);
      longint unsigned nu;
      int unsigned up;
      nu = (need < grow_units) ? longint'(grow_units) : need;
      if (arena_break + nu > ARENA_UNITS) return 0;
      up = arena_break;
      put_size(up, 32'(nu));
      arena_break += 32'(nu);
      return insert_block(up);
    endfunction

    function int unsigned take_block(longint unsigned bytes);
      longint unsigned need;
      int unsigned prev;
      int unsigned p;
      int unsigned steps;
      need = (bytes + 15) / 16 + 1;
      prev = rover;
      p = nx(rover);
      steps = 0;
      while (1) begin
        if (sz(p) >= need) begin
          if (sz(p) == need) begin
            put_next(prev, nx(p));
          end else begin
            put_size(p, 32'(sz(p) - need));
            p += sz(p);
            put_size(p, 32'(need));
          end
          rover = prev;
          return p + 1;
        end
        if (p == rover) begin
          if (!grow_arena(need)) return 0;
          p = rover;
        end
        prev = p;
        p = nx(p);
        steps++;
        if (steps > WALK_LIMIT) return 0;
      end
      return 0;
    endfunction

    function void note_request(func_t f, logic [31:0] bc, logic [15:0] ec,
                               logic [15:0] es, logic [13:0] fa);
      alloc_result_t r;
      int unsigned a;
      r.block_address = '0;
      r.status = 0;
      case (f)
        FUNC_ALLOC, FUNC_CALLOC: begin
          setup_list();
          if (f == FUNC_ALLOC) a = take_block(longint'(bc));
          else a = take_block(longint'(ec) * longint'(es));
          r.block_address = a[13:0];
          r.status = (a == 0);
          if (a == 0) n_alloc_fail++;
          else begin
            n_alloc_ok++;
            if (a < ARENA_UNITS) live_blocks.push_back(a);
          end
        end
        FUNC_FREE: begin
          setup_list();
          n_free++;
          if (fa >= 2 && fa - 1 < arena_break) void'(insert_block(32'(fa) - 1));
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function bit check_result(logic [13:0] addr, logic status, output string msg);
      alloc_result_t e;
      msg = "";
      if (pending.size() == 0) begin
        msg = $sformatf("unexpected word: block_address %0d status %0d", addr, status);
        return 0;
      end
      e = pending.pop_front();
      if (addr !== e.block_address)
        msg = $sformatf("block_address %0d, expected %0d", addr, e.block_address);
      if (status !== e.status)
        msg = {msg, $sformatf(" status %0d, expected %0d", status, e.status)};
      return msg == "";
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_func;
  logic [31:0] in_byte_count;
  logic [15:0] in_elem_count;
  logic [15:0] in_elem_size;
  logic [13:0] in_free_address;
  logic        out_valid;
  logic        out_ready;
  logic [13:0] out_block_address;
  logic        out_status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [14:0] cfg_grow_units;

  heap_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int stall_cycles;
  int results_seen;

  free_list_heap_allocator_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_byte_count(in_byte_count), .in_elem_count(in_elem_count),
    .in_elem_size(in_elem_size), .in_free_address(in_free_address),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_block_address(out_block_address), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_grow_units(cfg_grow_units)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    string msg;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (!sb.check_result(out_block_address, out_status, msg)) report_mismatch(msg);
    end
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic send_request(func_t f, logic [31:0] bc, logic [15:0] ec,
                              logic [15:0] es, logic [13:0] fa);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_byte_count <= bc;
    in_elem_count <= ec;
    in_elem_size <= es;
    in_free_address <= fa;
    do @(posedge clk); while (!(in_valid && in_ready));
    sb.note_request(f, bc, ec, es, fa);
  endtask

  // Drains outstanding words, then writes the grow setting while the core is idle.
  task automatic write_grow(logic [14:0] v);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_grow_units <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    sb.grow_units = {17'd0, v};
  endtask

  task automatic send_alloc(logic [31:0] bc);
    send_request(FUNC_ALLOC, bc, 16'($urandom), 16'($urandom), 14'($urandom));
  endtask

  task automatic send_free(logic [13:0] fa);
    send_request(FUNC_FREE, $urandom, 16'($urandom), 16'($urandom), fa);
  endtask

  // Frees the most recent live block that the shadow list returned.
  task automatic free_newest();
    if (sb.live_blocks.size() != 0) send_free(14'(sb.live_blocks.pop_back()));
  endtask

  task automatic random_request();
    int r;
    int k;
    logic [13:0] fa;
    logic [31:0] bc;
    r = $urandom_range(99);
    if (r < 6) begin
      // Noise: unused selector or a free that the core must ignore.
      if (r < 2) send_request(FUNC_NONE, $urandom, 16'($urandom), 16'($urandom),
                              14'($urandom));
      else begin
        if (r == 5 && sb.arena_break < ARENA_UNITS - 1)
          fa = 14'($urandom_range(ARENA_UNITS - 1, sb.arena_break + 1));
        else
          fa = 14'($urandom_range(1));
        send_free(fa);
      end
    end else if (sb.live_blocks.size() != 0 && (r < 48 || sb.live_blocks.size() > 48)) begin
      k = $urandom_range(sb.live_blocks.size() - 1);
      fa = 14'(sb.live_blocks[k]);
      sb.live_blocks.delete(k);
      send_free(fa);
    end else if (r < 80) begin
      k = $urandom_range(99);
      if (k < 70) bc = $urandom_range(256);
      else if (k < 90) bc = $urandom_range(4096);
      else if (k < 96) bc = $urandom_range(200000);
      else bc = $urandom;
      send_alloc(bc);
    end else begin
      if ($urandom_range(19) == 0)
        send_request(FUNC_CALLOC, $urandom, 16'($urandom), 16'($urandom), 14'($urandom));
      else
        send_request(FUNC_CALLOC, $urandom, 16'($urandom_range(32)),
                     16'($urandom_range(128)), 14'($urandom));
    end
  endtask

  initial begin
    sb = new();
    mismatches = 0;
    stall_cycles = 0;
    results_seen = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = FUNC_NONE;
    in_byte_count = '0;
    in_elem_count = '0;
    in_elem_size = '0;
    in_free_address = '0;
    cfg_valid = 1'b0;
    cfg_grow_units = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, with the reset grow setting.
    send_request(FUNC_NONE, '1, '1, '1, '1);
    send_free(14'd0);
    send_free(14'd1);
    send_free(14'h3fff);
    send_alloc(32'd0);
    send_alloc(32'd1);
    send_alloc(32'd16);
    send_alloc(32'd17);
    send_alloc(32'hffff_ffff);
    send_request(FUNC_CALLOC, '0, 16'hffff, 16'hffff, '0);
    send_request(FUNC_CALLOC, '0, 16'd0, 16'd0, '0);
    send_request(FUNC_CALLOC, '0, 16'd3, 16'd5, '0);
    send_alloc(32'd16 * 16000);
    send_alloc(32'd16 * 12000);
    // Three neighbors: free the outer ones, then the middle to merge both sides.
    send_alloc(32'd100);
    send_alloc(32'd100);
    send_alloc(32'd100);
    send_free(14'(sb.live_blocks[sb.live_blocks.size() - 1]));
    send_free(14'(sb.live_blocks[sb.live_blocks.size() - 3]));
    send_free(14'(sb.live_blocks[sb.live_blocks.size() - 2]));
    repeat (3) void'(sb.live_blocks.pop_back());
    repeat (4) free_newest();

    send_idle_pct = 33;
    recv_idle_pct = 74;
    write_grow(15'd1);
    repeat (300) random_request();

    send_idle_pct = 74;
    recv_idle_pct = 33;
    write_grow(15'd16384);
    repeat (300) random_request();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_grow(15'($urandom_range(16384, 1)));
    repeat (150) random_request();
    write_grow(15'd1024);
    repeat (150) random_request();

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Covered %0d results: %0d allocations granted, %0d refused, %0d frees.",
             results_seen, sb.n_alloc_ok, sb.n_alloc_fail, sb.n_free);
    $display("Grow setting swept over 1, 1024, 16384 and a random value; break at %0d.",
             sb.arena_break);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
